### rtl/bxt_pkg.sv
// shared constants, codes and control types of the binary trie max-xor multiset
`default_nettype none
package bxt_pkg;

  localparam int KEY_W         = 30;
  localparam int TDATA_W       = ((KEY_W + 7) / 8) * 8;
  localparam int COUNT_W       = 21;
  localparam int KEY_BITS_DEF  = 30;
  localparam int NODE_POOL_DEF = 1048576;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-level decisions handed from the node update logic to the walker
  typedef struct packed {
    logic wr;
    logic alloc;
    logic stop;
    logic acc_bit;
  } step_ctl_t;

endpackage
`default_nettype wire

### rtl/bxt_node_mem.sv
// node store: one write port, one read port with registered read data
`default_nettype none
module bxt_node_mem #(
  parameter int DEPTH  = 1048576,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 82
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/bxt_level.sv
// one trie level: edge count update, child allocation and branch choice
`default_nettype none
module bxt_level #(
  parameter int NODE_W = 20
) (
  input  wire bxt_pkg::action_t                       action,
  input  wire logic                                   key_bit,
  input  wire logic [NODE_W-1:0]                      next_free,
  input  wire logic [2*bxt_pkg::COUNT_W+2*NODE_W-1:0] cur_entry,
  output logic      [2*bxt_pkg::COUNT_W+2*NODE_W-1:0] new_entry,
  output logic      [NODE_W-1:0]                      next_node,
  output bxt_pkg::step_ctl_t                          ctl
);
  import bxt_pkg::*;

  logic [NODE_W-1:0]  link0, link1, link_b, link_o, link_b_new;
  logic [COUNT_W-1:0] cnt0, cnt1, cnt_b, cnt_o, cnt_b_new;

  assign {cnt1, cnt0, link1, link0} = cur_entry;
  assign link_b = key_bit ? link1 : link0;
  assign link_o = key_bit ? link0 : link1;
  assign cnt_b  = key_bit ? cnt1 : cnt0;
  assign cnt_o  = key_bit ? cnt0 : cnt1;

  always_comb begin
    cnt_b_new  = cnt_b;
    link_b_new = link_b;
    next_node  = link_b;
    ctl        = '0;
    unique case (action)
      ACT_INSERT: begin
        ctl.wr = 1'b1;
        if (cnt_b != COUNT_MAX) begin
          cnt_b_new = cnt_b + 1'b1;
        end
        if (link_b == '0) begin
          ctl.alloc  = 1'b1;
          link_b_new = next_free;
          next_node  = next_free;
        end
      end
      ACT_REMOVE: begin
        ctl.wr = 1'b1;
        if (cnt_b != '0) begin
          cnt_b_new = cnt_b - 1'b1;
        end
        ctl.stop = (link_b == '0);
      end
      ACT_QUERY: begin
        // take the opposite edge when it still leads to a stored key
        if (cnt_o != '0) begin
          ctl.acc_bit = 1'b1;
          next_node   = link_o;
        end
        ctl.stop = (next_node == '0);
      end
      default: begin
        ctl.stop = 1'b1;
      end
    endcase
  end

  assign new_entry = key_bit ? {cnt_b_new, cnt0, link_b_new, link0}
                             : {cnt1, cnt_b_new, link1, link_b_new};

endmodule
`default_nettype wire

### rtl/binary_trie_max_xor_multiset.sv
// top level: trie walker that serves insert, remove and max-xor query
//
//   channel | dir | tdata             | tuser
//   in_     | in  | key [29:0]        | action [1:0]
//   out_    | out | best_xor [29:0]   | status [1:0]
//
// a walking item goes from accept through the decide state (S_START), the walk
// over every trie level (S_WALK) and the output load (S_DONE) to the next accept.
// the level rate is set by the node store's registered read port: the next
// node is addressed from the current node's read data in the same cycle.
// reset clears the root node (kept in flops) and sets the allocation pointer
// to 1 at once; no clearing pass. a new beat is taken while a result still waits;
// the walker then holds before loading the output register.
`default_nettype none
module binary_trie_max_xor_multiset #(
  parameter int KEY_BITS  = bxt_pkg::KEY_BITS_DEF,
  parameter int NODE_POOL = bxt_pkg::NODE_POOL_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [bxt_pkg::TDATA_W-1:0] in_tdata,   // key
  input  wire logic [1:0]                  in_tuser,   // action
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [bxt_pkg::TDATA_W-1:0] out_tdata,  // best_xor
  output logic      [1:0]                  out_tuser   // status
);
  import bxt_pkg::*;

  localparam int NODE_W  = $clog2(NODE_POOL);
  localparam int NF_W    = $clog2(NODE_POOL + 1);
  localparam int ENTRY_W = 2 * COUNT_W + 2 * NODE_W;
  localparam int LVL_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  localparam logic [NF_W-1:0]  FULL_LIM = NF_W'(NODE_POOL - KEY_BITS);
  localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(KEY_BITS - 1);

  typedef enum logic [1:0] {S_IDLE, S_START, S_WALK, S_DONE} state_t;

  state_t              state_r;
  action_t             action_r;
  status_t             status_r, out_status_r;
  logic [KEY_BITS-1:0] key_sr_r, acc_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [NODE_W-1:0]   node_r;
  logic                fresh_r, dead_r, out_valid_r;
  logic [ENTRY_W-1:0]  root_r;
  logic [NF_W-1:0]     next_free_r;
  logic [KEY_W-1:0]    out_xor_r;

  logic [ENTRY_W-1:0]  rd_data, cur_entry, new_entry;
  logic [NODE_W-1:0]   next_node;
  step_ctl_t           ctl;
  logic                at_root, walking, mem_wr, root_empty, out_load;

  assign at_root    = (node_r == '0);
  // a node allocated one level up holds nothing yet
  assign cur_entry  = at_root ? root_r : (fresh_r ? '0 : rd_data);
  assign walking    = (state_r == S_WALK) && !dead_r;
  assign mem_wr     = walking && ctl.wr && !at_root;
  assign root_empty = (root_r[ENTRY_W-1 -: 2*COUNT_W] == '0);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  bxt_level #(
    .NODE_W(NODE_W)
  ) u_level (
    .action   (action_r),
    .key_bit  (key_sr_r[KEY_BITS-1]),
    .next_free(next_free_r[NODE_W-1:0]),
    .cur_entry(cur_entry),
    .new_entry(new_entry),
    .next_node(next_node),
    .ctl      (ctl)
  );

  bxt_node_mem #(
    .DEPTH (NODE_POOL),
    .ADDR_W(NODE_W),
    .DATA_W(ENTRY_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_wr),
    .wr_addr  (node_r),
    .wr_data  (new_entry),
    .rd_addr  (next_node),
    .rd_data_r(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      root_r      <= '0;
      next_free_r <= NF_W'(1);
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            action_r <= action_t'(in_tuser);
            key_sr_r <= KEY_BITS'(in_tdata[KEY_W-1:0]);
            state_r  <= S_START;
          end
        end
        S_START: begin
          acc_r    <= '0;
          lvl_r    <= LVL_TOP;
          node_r   <= '0;
          fresh_r  <= 1'b0;
          dead_r   <= 1'b0;
          unique case (action_r)
            ACT_INSERT: begin
              if (next_free_r > FULL_LIM) begin
                status_r <= ST_FULL;
                state_r  <= S_DONE;
              end else begin
                status_r <= ST_OK;
                state_r  <= S_WALK;
              end
            end
            ACT_REMOVE: begin
              status_r <= ST_OK;
              state_r  <= S_WALK;
            end
            ACT_QUERY: begin
              if (root_empty) begin
                status_r <= ST_EMPTY;
                state_r  <= S_DONE;
              end else begin
                status_r <= ST_OK;
                state_r  <= S_WALK;
              end
            end
            default: begin
              status_r <= ST_OK;
              state_r  <= S_DONE;
            end
          endcase
        end
        S_WALK: begin
          key_sr_r <= key_sr_r << 1;
          acc_r    <= KEY_BITS'({acc_r, walking & ctl.acc_bit});
          lvl_r    <= lvl_r - 1'b1;
          if (walking) begin
            if (ctl.wr && at_root) begin
              root_r <= new_entry;
            end
            if (ctl.alloc) begin
              next_free_r <= next_free_r + 1'b1;
            end
            node_r  <= next_node;
            fresh_r <= ctl.alloc;
            // past a missing child the remaining levels only shift in zeros
            dead_r  <= ctl.stop;
          end
          if (lvl_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_xor_r    <= KEY_W'(acc_r);
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_xor_r);
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

### rtl/bxt_checker.sv
// port-level checks of the trie max-xor multiset, bound to the top level
`default_nettype none
module bxt_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [bxt_pkg::TDATA_W-1:0] out_tdata,
  input wire logic [1:0]                  out_tuser
);
  import bxt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // the walker goes through its decide state after each beat before it takes another
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat taken in back-to-back cycles");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_EMPTY) || (out_tuser == ST_FULL))
    else $error("undefined status code");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("nonzero best_xor on failed operation");

endmodule

bind binary_trie_max_xor_multiset bxt_checker u_bxt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire

### tb/tb_binary_trie_max_xor_multiset.sv
// testbench for the binary trie max-xor multiset: random stream traffic against a trie predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_binary_trie_max_xor_multiset;
  import bxt_pkg::*;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
  } trie_op_t;

  typedef struct packed {
    logic [KEY_W-1:0] best_xor;
    status_t          status;
  } trie_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;   // key
  logic [1:0]         in_tuser = '0;   // action
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;       // best_xor
  logic [1:0]         out_tuser;       // status

  binary_trie_max_xor_multiset i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // trie mirror: links and edge counts per node, root cleared at reset
  bit [20:0]        trie_link [NODE_POOL_DEF][2];
  bit [COUNT_W-1:0] trie_cnt  [NODE_POOL_DEF][2];
  int unsigned      free_node = 1;

  trie_op_t         pending_ops[$];
  trie_result_t     awaited_results[$];
  logic [KEY_W-1:0] held_keys[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_errors = 0;
  int n_beats = 0;
  int n_checked = 0;
  int n_dropped = 0;
  int n_empty = 0;
  int n_inserts = 0;
  int n_removes = 0;
  int n_queries = 0;

  function automatic trie_result_t trie_apply(logic [1:0] action, logic [KEY_W-1:0] key);
    trie_result_t res;
    int unsigned node;
    int unsigned nxt;
    bit b;
    bit take;
    res.best_xor = '0;
    res.status = ST_OK;
    node = 0;
    case (action)
      ACT_INSERT: begin
        n_inserts++;
        // one path may need a node per level, so refuse before walking
        if (int'(NODE_POOL_DEF) - int'(free_node) < KEY_BITS_DEF) begin
          res.status = ST_FULL;
          n_dropped++;
        end else begin
          for (int lvl = KEY_BITS_DEF - 1; lvl >= 0; lvl--) begin
            b = key[lvl];
            if (trie_cnt[node][b] != COUNT_MAX) trie_cnt[node][b] = trie_cnt[node][b] + 1'b1;
            nxt = trie_link[node][b];
            if (nxt == 0) begin
              nxt = free_node;
              free_node++;
              trie_link[nxt][0] = '0;
              trie_link[nxt][1] = '0;
              trie_cnt[nxt][0] = '0;
              trie_cnt[nxt][1] = '0;
              trie_link[node][b] = nxt[20:0];
            end
            node = nxt;
          end
        end
      end
      ACT_REMOVE: begin
        n_removes++;
        for (int lvl = KEY_BITS_DEF - 1; lvl >= 0; lvl--) begin
          b = key[lvl];
          if (trie_cnt[node][b] != 0) trie_cnt[node][b] = trie_cnt[node][b] - 1'b1;
          node = trie_link[node][b];
          if (node == 0) break;
        end
      end
      ACT_QUERY: begin
        n_queries++;
        if (trie_cnt[0][0] == 0 && trie_cnt[0][1] == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          for (int lvl = KEY_BITS_DEF - 1; lvl >= 0; lvl--) begin
            b = key[lvl];
            take = b;
            if (trie_cnt[node][b ^ 1'b1] != 0) begin
              take = b ^ 1'b1;
              res.best_xor[lvl] = 1'b1;
            end
            node = trie_link[node][take];
            if (node == 0) break;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : drive_proc
    trie_op_t op;
    trie_result_t res;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        res = trie_apply(in_tuser, in_tdata[KEY_W-1:0]);
        awaited_results = {awaited_results, res};
        n_beats++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(TDATA_W - KEY_W){1'b0}}, op.key};
          in_tuser <= op.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : sink_proc
    trie_result_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: best_xor %h status %0d",
                   $time, out_tdata, out_tuser);
          n_errors++;
        end else begin
          exp_res = awaited_results.pop_front();
          n_checked++;
          if (out_tdata !== {{(TDATA_W - KEY_W){1'b0}}, exp_res.best_xor}) begin
            $display("%0t: best_xor mismatch: expected %h actual %h",
                     $time, exp_res.best_xor, out_tdata);
            n_errors++;
          end
          if (out_tuser !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_res.status, out_tuser);
            n_errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_op(logic [1:0] action, logic [KEY_W-1:0] key);
    trie_op_t op;
    op.action = action;
    op.key = key;
    pending_ops = {pending_ops, op};
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  // mostly inserts and queries, removes of held keys, some absent removes and junk actions
  task automatic push_random_ops(int count);
    logic [KEY_W-1:0] cluster;
    logic [KEY_W-1:0] key;
    int roll;
    int idx;
    cluster = KEY_W'($urandom);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      key = KEY_W'($urandom);
      if (roll < 40) begin
        if (held_keys.size() != 0 && $urandom_range(3) == 0)
          key = held_keys[$urandom_range(held_keys.size() - 1)];
        else if ($urandom_range(1) == 0)
          key = {cluster[KEY_W-1:10], 10'($urandom_range(1023))};
        push_op(ACT_INSERT, key);
        held_keys = {held_keys, key};
      end else if (roll < 65) begin
        if (held_keys.size() != 0 && $urandom_range(4) != 0) begin
          idx = $urandom_range(held_keys.size() - 1);
          key = held_keys[idx];
          held_keys.delete(idx);
        end
        push_op(ACT_REMOVE, key);
      end else if (roll < 95) begin
        if (held_keys.size() != 0) begin
          idx = $urandom_range(held_keys.size() - 1);
          case ($urandom_range(3))
            0: key = ~held_keys[idx];
            1: key = held_keys[idx];
            default: ;
          endcase
        end
        push_op(ACT_QUERY, key);
      end else begin
        push_op(ACT_UNKNOWN, key);
      end
    end
  endtask

  initial begin : watchdog
    #(100_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main_proc
    trie_link[0][0] = '0;
    trie_link[0][1] = '0;
    trie_cnt[0][0] = '0;
    trie_cnt[0][1] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 67;
    // empty set, absent removes, extremes, duplicates and junk action
    push_op(ACT_QUERY, '0);
    push_op(ACT_REMOVE, 30'd5);
    push_op(ACT_QUERY, '1);
    push_op(ACT_UNKNOWN, '1);
    push_op(ACT_INSERT, '0);
    push_op(ACT_INSERT, '1);
    push_op(ACT_QUERY, '0);
    push_op(ACT_QUERY, '1);
    push_op(ACT_QUERY, 30'h2AAAAAAA);
    push_op(ACT_INSERT, '0);
    push_op(ACT_REMOVE, '0);
    push_op(ACT_QUERY, '1);
    push_op(ACT_REMOVE, '0);
    push_op(ACT_QUERY, '1);
    push_op(ACT_REMOVE, '1);
    push_op(ACT_QUERY, 30'd12345);
    push_op(ACT_REMOVE, 30'd1);
    push_op(ACT_INSERT, 30'h20000000);
    push_op(ACT_INSERT, 30'h1FFFFFFF);
    push_op(ACT_QUERY, '0);
    push_op(ACT_QUERY, '1);
    push_op(ACT_UNKNOWN, '0);
    push_op(ACT_REMOVE, 30'h20000000);
    push_op(ACT_QUERY, 30'h15555555);
    held_keys = {held_keys, 30'h1FFFFFFF};
    push_random_ops(267);
    wait_drained();

    send_idle_pct = 67;
    recv_idle_pct = 27;
    push_random_ops(267);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_ops(266);
    wait_drained();

    repeat (64) @(posedge clk);
    $display("%0d beats: %0d inserts (%0d dropped on full pool), %0d removes, %0d queries",
             n_beats, n_inserts, n_dropped, n_removes, n_queries);
    $display("%0d results checked, %0d empty-set queries, %0d nodes used, %0d errors",
             n_checked, n_empty, free_node, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/bxt_pkg.sv
rtl/bxt_node_mem.sv
rtl/bxt_level.sv
rtl/binary_trie_max_xor_multiset.sv
rtl/bxt_checker.sv
tb/tb_binary_trie_max_xor_multiset.sv
